@@ src/ula_pkg.sv @@
// Shared constants, codes and command/status types for the UART line assembler FIFO.
`default_nettype none
package ula_pkg;

   // Sizing of the line buffer and of the ring of stored lines.
   localparam int LINE_BYTES = 64;
   localparam int FIFO_DEPTH = 8;
   localparam int IDX_W      = $clog2(LINE_BYTES);
   localparam int SLOT_W     = $clog2(FIFO_DEPTH);
   localparam int COUNT_W    = $clog2(FIFO_DEPTH + 1);
   localparam int ADDR_W     = SLOT_W + IDX_W;
   localparam int BYTE_W     = 8;
   localparam int FUNC_W     = 2;

   // Request function codes.
   localparam logic [FUNC_W-1:0] FUNC_RX    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

   // Special byte values.
   localparam logic [BYTE_W-1:0] CR_BYTE   = 8'h0D;
   localparam logic [BYTE_W-1:0] EMPTY_LEN = 8'hFF;

   // Selection of what the response register is loaded with.
   typedef logic [1:0] rsp_sel_type;
   localparam rsp_sel_type RSP_SEL_BYTE      = 2'd0;
   localparam rsp_sel_type RSP_SEL_POP_EMPTY = 2'd1;
   localparam rsp_sel_type RSP_SEL_QUERY     = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        asm_wr;
      logic        fill_inc;
      logic        fill_clr;
      logic        copy_clr;
      logic        copy_inc;
      logic        store_wr;
      logic        push_commit;
      logic        pop_idx_clr;
      logic        pop_idx_inc;
      logic        pop_commit;
      logic        rsp_ld;
      rsp_sel_type rsp_sel;
   } ula_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic fill_full;
      logic rx_is_cr;
      logic empty;
      logic full;
      logic copy_last;
      logic pop_last;
   } ula_sts_type;

endpackage
`default_nettype wire

@@ src/ula_if.sv @@
// Valid/ready channel interfaces for the request and response sides.
`default_nettype none
interface ula_req_if;
   logic                          valid;
   logic                          ready;
   logic [ula_pkg::FUNC_W-1:0]    func;
   logic [ula_pkg::BYTE_W-1:0]    rx_byte;

   modport source (output valid, output func, output rx_byte, input ready);
   modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface ula_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ula_pkg::BYTE_W-1:0]    line_byte;
   logic [ula_pkg::BYTE_W-1:0]    line_length;
   logic                          last;
   logic                          ok;

   modport source (output valid, output line_byte, output line_length, output last,
                   output ok, input ready);
   modport sink   (input valid, input line_byte, input line_length, input last,
                   input ok, output ready);
endinterface
`default_nettype wire

@@ src/uart_line_assembler_fifo.sv @@
// A received byte is written to the assembly buffer on acceptance; a CR then copies the
// line byte by byte through COPY_RD and COPY_WR. A query or an empty pop gives its
// transaction in the cycle after acceptance. A pop passes through POP_RD and POP_LD before
// each byte and waits for the sink to take it; each byte is a read of the line store.
// One request is handled at a time. Synchronous reset clears the fill index, ring
// pointers and line count at once; the buffers are not cleared and need no sweep.
`default_nettype none
module uart_line_assembler_fifo (
   input  wire logic  clock,
   input  wire logic  reset,
   ula_req_if.sink    req_chan,
   ula_rsp_if.source  rsp_chan
);
   import ula_pkg::*;

   ula_cmd_type cmd;
   ula_sts_type sts;

   // Sequencing.
   ula_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Storage and response register.
   ula_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .rx_byte     (req_chan.rx_byte),
      .sts         (sts),
      .line_byte   (rsp_chan.line_byte),
      .line_length (rsp_chan.line_length),
      .last        (rsp_chan.last),
      .ok          (rsp_chan.ok)
   );

`ifndef SYNTH
   // Requests are never taken while a reply is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !rsp_chan.valid)
      else $error("request ready while a response is pending");

   // A line is never pushed and popped in the same cycle.
   a_push_pop_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push_commit && cmd.pop_commit))
      else $error("push and pop committed together");

   // After a pop the ring cannot be full.
   a_pop_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_commit |=> !sts.full)
      else $error("ring full straight after a pop");

   // The final transaction of a request frees the block for the next one.
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last) |=> req_chan.ready)
      else $error("block not ready after final response");
`endif

endmodule
`default_nettype wire

@@ src/ula_ctrl.sv @@
// Controller state machine: sequences byte intake, line copy, pop streaming and replies.
`default_nettype none
module ula_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic [ula_pkg::FUNC_W-1:0]   req_func,
   output logic                              req_ready,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   input  wire ula_pkg::ula_sts_type         sts,
   output ula_pkg::ula_cmd_type              cmd
);
   import ula_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_COPY_RD  = 3'd1;
   localparam logic [2:0] ST_COPY_WR  = 3'd2;
   localparam logic [2:0] ST_POP_RD   = 3'd3;
   localparam logic [2:0] ST_POP_LD   = 3'd4;
   localparam logic [2:0] ST_RSP_BYTE = 3'd5;
   localparam logic [2:0] ST_RSP_LAST = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       req_take;
   logic       rsp_take;

   // Handshake qualifiers.
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RSP_BYTE) || (state_ff == ST_RSP_LAST);
   assign req_take  = req_valid && req_ready;
   assign rsp_take  = rsp_valid && rsp_ready;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp_sel = RSP_SEL_BYTE;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_func)
                  FUNC_RX: begin
                     if (sts.fill_full) begin
                        cmd.fill_clr = 1'b1;
                     end else begin
                        cmd.asm_wr   = 1'b1;
                        cmd.fill_inc = 1'b1;
                        if (sts.rx_is_cr) begin
                           cmd.copy_clr = 1'b1;
                           state_in     = ST_COPY_RD;
                        end
                     end
                  end
                  FUNC_POP: begin
                     if (sts.empty) begin
                        cmd.rsp_ld  = 1'b1;
                        cmd.rsp_sel = RSP_SEL_POP_EMPTY;
                        state_in    = ST_RSP_LAST;
                     end else begin
                        cmd.pop_idx_clr = 1'b1;
                        state_in        = ST_POP_RD;
                     end
                  end
                  FUNC_QUERY: begin
                     cmd.rsp_ld  = 1'b1;
                     cmd.rsp_sel = RSP_SEL_QUERY;
                     state_in    = ST_RSP_LAST;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_COPY_RD: begin
            state_in = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            cmd.store_wr = 1'b1;
            if (sts.copy_last) begin
               cmd.push_commit = 1'b1;
               cmd.fill_clr    = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               cmd.copy_inc = 1'b1;
               state_in     = ST_COPY_RD;
            end
         end
         ST_POP_RD: begin
            state_in = ST_POP_LD;
         end
         ST_POP_LD: begin
            cmd.rsp_ld  = 1'b1;
            cmd.rsp_sel = RSP_SEL_BYTE;
            if (sts.pop_last) begin
               cmd.pop_commit = 1'b1;
               state_in       = ST_RSP_LAST;
            end else begin
               state_in = ST_RSP_BYTE;
            end
         end
         ST_RSP_BYTE: begin
            if (rsp_take) begin
               cmd.pop_idx_inc = 1'b1;
               state_in        = ST_POP_RD;
            end
         end
         ST_RSP_LAST: begin
            if (rsp_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

@@ src/ula_dpath.sv @@
// Datapath: assembly buffer, line store, ring pointers and the response register.
`default_nettype none
module ula_dpath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ula_pkg::ula_cmd_type         cmd,
   input  wire logic [ula_pkg::BYTE_W-1:0]   rx_byte,
   output ula_pkg::ula_sts_type              sts,
   output logic [ula_pkg::BYTE_W-1:0]        line_byte,
   output logic [ula_pkg::BYTE_W-1:0]        line_length,
   output logic                              last,
   output logic                              ok
);
   import ula_pkg::*;

   // Advance a slot pointer round the ring.
   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] r;
      if (s == SLOT_W'(FIFO_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = SLOT_W'(s + 1'b1);
      end
      return r;
   endfunction

   logic [BYTE_W-1:0]  asm_mem [2**IDX_W];
   logic [BYTE_W-1:0]  store_mem [2**ADDR_W];
   logic [IDX_W-1:0]   slot_len_ff [FIFO_DEPTH];

   logic [BYTE_W-1:0]  asm_rdata_ff;
   logic [BYTE_W-1:0]  store_rdata_ff;

   logic [IDX_W-1:0]   fill_ff, fill_in;
   logic [IDX_W-1:0]   copy_idx_ff, copy_idx_in;
   logic [IDX_W-1:0]   pop_idx_ff, pop_idx_in;
   logic [SLOT_W-1:0]  head_ff, head_in;
   logic [SLOT_W-1:0]  tail_ff, tail_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic [BYTE_W-1:0]  line_byte_ff, line_byte_in;
   logic [BYTE_W-1:0]  line_length_ff, line_length_in;
   logic               last_ff, last_in;
   logic               ok_ff, ok_in;

   logic [IDX_W-1:0]   tail_len;

   assign tail_len = slot_len_ff[tail_ff];

   // Status towards the controller.
   always_comb begin
      sts.fill_full = (fill_ff == IDX_W'(LINE_BYTES - 1));
      sts.rx_is_cr  = (rx_byte == CR_BYTE);
      sts.empty     = (count_ff == '0);
      sts.full      = (count_ff == COUNT_W'(FIFO_DEPTH));
      sts.copy_last = (copy_idx_ff == IDX_W'(fill_ff - 1'b1));
      sts.pop_last  = (pop_idx_ff == IDX_W'(tail_len - 1'b1));
   end

   // Assembly buffer: byte written on intake, read back during the line copy.
   always_ff @(posedge clock) begin
      if (cmd.asm_wr) begin
         asm_mem[fill_ff] <= rx_byte;
      end
      asm_rdata_ff <= asm_mem[copy_idx_ff];
   end

   // Line store: written during the copy, read while a line is popped.
   always_ff @(posedge clock) begin
      if (cmd.store_wr) begin
         store_mem[{head_ff, copy_idx_ff}] <= asm_rdata_ff;
      end
      store_rdata_ff <= store_mem[{tail_ff, pop_idx_ff}];
   end

   // Length of each stored line, recorded when the line is committed.
   always_ff @(posedge clock) begin
      if (cmd.push_commit) begin
         slot_len_ff[head_ff] <= fill_ff;
      end
   end

   // Index counters and ring pointers.
   always_comb begin
      fill_in     = fill_ff;
      copy_idx_in = copy_idx_ff;
      pop_idx_in  = pop_idx_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      if (cmd.fill_clr) begin
         fill_in = '0;
      end else if (cmd.fill_inc) begin
         fill_in = IDX_W'(fill_ff + 1'b1);
      end
      if (cmd.copy_clr) begin
         copy_idx_in = '0;
      end else if (cmd.copy_inc) begin
         copy_idx_in = IDX_W'(copy_idx_ff + 1'b1);
      end
      if (cmd.pop_idx_clr) begin
         pop_idx_in = '0;
      end else if (cmd.pop_idx_inc) begin
         pop_idx_in = IDX_W'(pop_idx_ff + 1'b1);
      end
      // A push into a full ring overwrites the oldest line, so both pointers move.
      if (cmd.push_commit) begin
         head_in = next_slot(head_ff);
         if (sts.full) begin
            tail_in = next_slot(tail_ff);
         end else begin
            count_in = COUNT_W'(count_ff + 1'b1);
         end
      end else if (cmd.pop_commit) begin
         tail_in  = next_slot(tail_ff);
         count_in = COUNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         copy_idx_ff <= '0;
         pop_idx_ff  <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
      end else begin
         fill_ff     <= fill_in;
         copy_idx_ff <= copy_idx_in;
         pop_idx_ff  <= pop_idx_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
      end
   end

   // Response register contents for each kind of reply.
   always_comb begin
      line_byte_in   = line_byte_ff;
      line_length_in = line_length_ff;
      last_in        = last_ff;
      ok_in          = ok_ff;
      if (cmd.rsp_ld) begin
         case (cmd.rsp_sel)
            RSP_SEL_BYTE: begin
               line_byte_in   = store_rdata_ff;
               line_length_in = BYTE_W'(tail_len);
               last_in        = sts.pop_last;
               ok_in          = 1'b1;
            end
            RSP_SEL_QUERY: begin
               line_byte_in = '0;
               last_in      = 1'b1;
               if (sts.empty) begin
                  line_length_in = EMPTY_LEN;
                  ok_in          = 1'b0;
               end else begin
                  line_length_in = BYTE_W'(tail_len);
                  ok_in          = 1'b1;
               end
            end
            default: begin
               line_byte_in   = '0;
               line_length_in = '0;
               last_in        = 1'b1;
               ok_in          = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      line_byte_ff   <= line_byte_in;
      line_length_ff <= line_length_in;
      last_ff        <= last_in;
      ok_ff          <= ok_in;
   end

   assign line_byte   = line_byte_ff;
   assign line_length = line_length_ff;
   assign last        = last_ff;
   assign ok          = ok_ff;

endmodule
`default_nettype wire

@@ verif/ula_line_scoreboard_pkg.sv @@
// Scoreboard class that predicts and checks the responses of the UART line assembler FIFO.
package ula_line_scoreboard_pkg;
   import ula_pkg::*;

   // One response transaction as seen on the result channel.
   typedef struct packed {
      logic [BYTE_W-1:0] line_byte;
      logic [BYTE_W-1:0] line_length;
      logic              last;
      logic              ok;
   } line_rsp_type;

   class line_fifo_scoreboard;
      // Predicted state: the line being gathered and the ring of stored lines.
      logic [BYTE_W-1:0] gather_buf [LINE_BYTES];
      int                gather_count;
      logic [BYTE_W-1:0] stored_lines [FIFO_DEPTH][LINE_BYTES];
      int                stored_len [FIFO_DEPTH];
      int                write_slot;
      int                read_slot;
      int                lines_held;

      // Responses still owed by the block, oldest first.
      line_rsp_type      awaited_rsp [$];

      // Error count and a few figures for the closing summary.
      int mismatches;
      int rsp_checked;
      int lines_pushed;
      int lines_overwritten;
      int lines_dropped;
      int pops_done;
      int pops_empty;
      int queries;

      function new();
         gather_count      = 0;
         write_slot        = 0;
         read_slot         = 0;
         lines_held        = 0;
         mismatches        = 0;
         rsp_checked       = 0;
         lines_pushed      = 0;
         lines_overwritten = 0;
         lines_dropped     = 0;
         pops_done         = 0;
         pops_empty        = 0;
         queries           = 0;
      endfunction

      function int pending();
         return awaited_rsp.size();
      endfunction

      // Updates the predicted state for one accepted request and queues the responses it owes.
      function void note_request(input logic [FUNC_W-1:0] func, input logic [BYTE_W-1:0] rx);
         line_rsp_type r;
         int           slot;
         case (func)
            FUNC_RX: begin
               // A byte is kept only while there is room; otherwise the line starts afresh.
               if (gather_count < LINE_BYTES - 1) begin
                  gather_buf[gather_count] = rx;
                  gather_count++;
                  if (rx == CR_BYTE) begin
                     // The line, carriage return included, goes into the next slot.
                     for (int i = 0; i < gather_count; i++)
                        stored_lines[write_slot][i] = gather_buf[i];
                     stored_len[write_slot] = gather_count;
                     write_slot = (write_slot + 1) % FIFO_DEPTH;
                     if (lines_held < FIFO_DEPTH) begin
                        lines_held++;
                     end else begin
                        // A full ring loses its oldest line.
                        read_slot = (read_slot + 1) % FIFO_DEPTH;
                        lines_overwritten++;
                     end
                     lines_pushed++;
                     gather_count = 0;
                  end
               end else begin
                  gather_count = 0;
                  lines_dropped++;
               end
            end
            FUNC_POP: begin
               if (lines_held == 0) begin
                  r = '{line_byte: '0, line_length: '0, last: 1'b1, ok: 1'b0};
                  awaited_rsp.push_back(r);
                  pops_empty++;
               end else begin
                  // One transaction per stored byte, the last one flagged.
                  slot = read_slot;
                  for (int i = 0; i < stored_len[slot]; i++) begin
                     r.line_byte   = stored_lines[slot][i];
                     r.line_length = BYTE_W'(stored_len[slot]);
                     r.last        = (i == stored_len[slot] - 1);
                     r.ok          = 1'b1;
                     awaited_rsp.push_back(r);
                  end
                  read_slot = (slot + 1) % FIFO_DEPTH;
                  lines_held--;
                  pops_done++;
               end
            end
            FUNC_QUERY: begin
               r.line_byte = '0;
               r.last      = 1'b1;
               if (lines_held == 0) begin
                  r.line_length = EMPTY_LEN;
                  r.ok          = 1'b0;
               end else begin
                  r.line_length = BYTE_W'(stored_len[read_slot]);
                  r.ok          = 1'b1;
               end
               awaited_rsp.push_back(r);
               queries++;
            end
            default: begin
               // The spare function code is accepted and has no effect.
            end
         endcase
      endfunction

      task report_mismatch(input string what);
         mismatches++;
         if (mismatches <= 20)
            $display("ERROR: %s", what);
      endtask

      // Compares one received response with the oldest one owed.
      task check_response(input line_rsp_type got);
         line_rsp_type want;
         if (awaited_rsp.size() == 0) begin
            report_mismatch($sformatf("response with nothing owed: byte %02h length %0d last %0b ok %0b",
                                      got.line_byte, got.line_length, got.last, got.ok));
            return;
         end
         want = awaited_rsp.pop_front();
         rsp_checked++;
         if (got.line_byte !== want.line_byte)
            report_mismatch($sformatf("response %0d: line_byte %02h, expected %02h",
                                      rsp_checked, got.line_byte, want.line_byte));
         if (got.line_length !== want.line_length)
            report_mismatch($sformatf("response %0d: line_length %0d, expected %0d",
                                      rsp_checked, got.line_length, want.line_length));
         if (got.last !== want.last)
            report_mismatch($sformatf("response %0d: last %b, expected %b",
                                      rsp_checked, got.last, want.last));
         if (got.ok !== want.ok)
            report_mismatch($sformatf("response %0d: ok %b, expected %b",
                                      rsp_checked, got.ok, want.ok));
      endtask
   endclass

endpackage

@@ verif/uart_line_assembler_fifo_test.sv @@
// Testbench top: directed and random traffic into the line assembler FIFO, with scoreboard.
module uart_line_assembler_fifo_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ula_pkg::*;
   import ula_line_scoreboard_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int REQ_ITEMS    = 260;
   localparam int SETTLE_CYCLES = 2 * LINE_BYTES + 16;

   logic clock = 1'b0;
   logic reset;
   bit   no_idle = 1'b0;
   int   items_sent = 0;
   int   lines_built = 0;

   line_fifo_scoreboard line_sb = new();

   ula_req_if req_bus ();
   ula_rsp_if rsp_bus ();

   uart_line_assembler_fifo uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Idle cycles before a transaction on either side; none during a calm stretch.
   function automatic int idle_cycles();
      return no_idle ? 0 : $urandom_range(0, 4);
   endfunction

   // Offers one request and waits until it is taken; valid stays high afterwards.
   task automatic send_item(input logic [FUNC_W-1:0] func, input logic [BYTE_W-1:0] rx);
      int gap = idle_cycles();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.func    <= func;
      req_bus.rx_byte <= rx;
      do @(posedge clock); while (!req_bus.ready);
      line_sb.note_request(func, rx);
      if (func != FUNC_UNUSED)
         items_sent++;
   endtask

   // Sends a line of random bytes closed by a carriage return, with the odd pop or query.
   task automatic send_line(input int body_len);
      logic [BYTE_W-1:0] b;
      for (int i = 0; i < body_len; i++) begin
         b = BYTE_W'($urandom_range(0, 255));
         if (b == CR_BYTE)
            b = b ^ 8'h80;
         send_item(FUNC_RX, b);
         if ($urandom_range(0, 15) == 0)
            send_item($urandom_range(0, 1) ? FUNC_POP : FUNC_QUERY,
                      BYTE_W'($urandom_range(0, 255)));
      end
      send_item(FUNC_RX, CR_BYTE);
      lines_built++;
   endtask

   // Holds off the sender until every owed response has arrived.
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (line_sb.pending() != 0);
   endtask

   // Result side: random stalls, every accepted transaction goes to the scoreboard.
   initial begin
      int           gap;
      line_rsp_type got;
      rsp_bus.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         gap = idle_cycles();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.line_byte   = rsp_bus.line_byte;
         got.line_length = rsp_bus.line_length;
         got.last        = rsp_bus.last;
         got.ok          = rsp_bus.ok;
         line_sb.check_response(got);
      end
   end

   // Request side: reset, directed cases, then random traffic.
   initial begin
      int round_no;
      int pick;
      int line_share;
      int pop_share;
      bit drained;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.func    <= FUNC_RX;
      req_bus.rx_byte <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Empty ring: query, pop and the spare code.
      send_item(FUNC_QUERY, 8'h00);
      send_item(FUNC_POP, 8'hFF);
      send_item(FUNC_UNUSED, 8'hA5);
      // A bare carriage return makes a one-byte line.
      send_item(FUNC_RX, CR_BYTE);
      send_item(FUNC_QUERY, 8'hFF);
      send_item(FUNC_POP, 8'h00);
      // Extreme byte values in one line, popped until the ring is empty again.
      send_item(FUNC_RX, 8'h00);
      send_item(FUNC_RX, 8'hFF);
      send_item(FUNC_RX, CR_BYTE);
      send_item(FUNC_QUERY, 8'h00);
      send_item(FUNC_POP, 8'h00);
      send_item(FUNC_POP, 8'h00);
      send_item(FUNC_QUERY, 8'h00);
      // Nine lines into eight slots: the first one is overwritten.
      send_item(FUNC_RX, 8'h11);
      send_item(FUNC_RX, CR_BYTE);
      repeat (7) send_item(FUNC_RX, CR_BYTE);
      send_item(FUNC_RX, 8'h22);
      send_item(FUNC_RX, CR_BYTE);
      send_item(FUNC_POP, 8'h00);

      // Random traffic alternating between filling and emptying phases.
      round_no = 0;
      drained  = 1'b0;
      while (items_sent < REQ_ITEMS) begin
         if (round_no % 25 == 24)
            no_idle = !no_idle;
         if (!drained && items_sent >= REQ_ITEMS / 2) begin
            wait_for_drain();
            drained = 1'b1;
         end
         if ((round_no / 12) % 2 == 0) begin
            line_share = 60;
            pop_share  = 15;
         end else begin
            line_share = 20;
            pop_share  = 55;
         end
         pick = $urandom_range(0, 99);
         if (pick < line_share) begin
            // Every sixth line is near or past the length limit.
            if (lines_built % 6 == 5)
               send_line($urandom_range(LINE_BYTES - 3, LINE_BYTES));
            else
               send_line($urandom_range(0, 6));
         end else if (pick < line_share + pop_share) begin
            send_item(FUNC_POP, BYTE_W'($urandom_range(0, 255)));
         end else if (pick < line_share + pop_share + 15) begin
            send_item(FUNC_QUERY, BYTE_W'($urandom_range(0, 255)));
         end else if (pick % 2 == 0) begin
            send_item(FUNC_UNUSED, BYTE_W'($urandom_range(0, 255)));
         end else begin
            // A stray byte that joins whatever line comes next.
            send_item(FUNC_RX, BYTE_W'($urandom_range(0, 255)));
         end
         round_no++;
      end

      // Let the last responses and any line copy finish.
      req_bus.valid <= 1'b0;
      while (line_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d requests and %0d response transactions.",
               items_sent, line_sb.rsp_checked);
      $display("Lines stored: %0d, overwritten: %0d, too long: %0d; pops: %0d, %s %0d, %s %0d.",
               line_sb.lines_pushed, line_sb.lines_overwritten, line_sb.lines_dropped,
               line_sb.pops_done, "empty pops:", line_sb.pops_empty,
               "queries:", line_sb.queries);
      if (line_sb.mismatches == 0)
         $display("uart_line_assembler_fifo: match");
      else
         $display("uart_line_assembler_fifo: mismatch");
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #15_000_000;
      $display("Timed out with %0d response transactions still owed.", line_sb.pending());
      $display("uart_line_assembler_fifo: mismatch");
      $finish;
   end

endmodule
